// File: hw/rtl/lcg_pkg.sv
// Shared widths, types and helpers for the lifetime colour gradient block.
package lcg_pkg;

   localparam int AGE_W        = 16;
   localparam int CHAN_W       = 12;
   localparam int COL_W        = 8;
   localparam int NUM_CHAN     = 4;
   localparam int KEY_WORD_W   = 64;
   localparam int CSR_IDX_W    = 3;
   localparam int MAX_KEYS_DEF = 6;
   localparam int PROD_W       = CHAN_W + AGE_W;
   localparam int NUMER_W      = PROD_W + 1;
   localparam int SCALED_W     = NUMER_W + COL_W;
   localparam int FRAC_SHIFT   = CHAN_W - 1;
   localparam int QUOT_W       = 9;
   localparam int DIVIDEND_W   = AGE_W + QUOT_W;

   typedef logic [NUM_CHAN-1:0][COL_W-1:0]      rgba_type;
   typedef logic [NUM_CHAN-1:0][DIVIDEND_W-1:0] dividend_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLOUR_MODE = 3'd0,
      CSR_KEY_COUNT   = 3'd1,
      CSR_KEY_WORD_0  = 3'd2
   } csr_index_type;

   function automatic logic [AGE_W-1:0] key_time(input logic [KEY_WORD_W-1:0] word);
      return word[KEY_WORD_W-1 -: AGE_W];
   endfunction

   function automatic logic [CHAN_W-1:0] key_chan(input logic [KEY_WORD_W-1:0] word,
                                                  input int ch);
      return CHAN_W'(word >> (CHAN_W * (NUM_CHAN - 1 - ch)));
   endfunction

endpackage

// File: hw/rtl/lcg_age_div.sv
// Pipelined restoring divider that turns remaining and total life into a Q0.16 age.
module lcg_age_div import lcg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [AGE_W-1:0] in_left,
   input  logic [AGE_W-1:0] in_total,
   input  rgba_type         in_colour,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [AGE_W-1:0] out_age,
   output rgba_type         out_colour
);

   localparam int STAGES = AGE_W + 1;

   logic             v_ff     [STAGES];
   logic             rdy      [STAGES];
   logic [AGE_W-1:0] rem_ff   [STAGES];
   logic [AGE_W-1:0] q_ff     [STAGES];
   logic [AGE_W-1:0] tot_ff   [STAGES];
   logic             full_ff  [STAGES];
   rgba_type         col_ff   [STAGES];
   logic [AGE_W-1:0] rem_in   [STAGES];
   logic [AGE_W-1:0] q_in     [STAGES];
   logic             full_in0;

   always_comb begin
      rdy[STAGES-1] = !v_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   // entry: left above total gives age zero, a full lifetime saturates
   always_comb begin
      logic [AGE_W-1:0] diff;
      logic [AGE_W:0]   r2;
      diff = in_total - in_left;
      if (in_left > in_total) begin
         rem_in[0] = '0;
         full_in0  = 1'b0;
      end else begin
         rem_in[0] = diff;
         full_in0  = (diff == in_total);
      end
      q_in[0] = '0;
      for (int k = 1; k < STAGES; k++) begin
         r2 = {rem_ff[k-1], 1'b0};
         if (r2 >= {1'b0, tot_ff[k-1]}) begin
            rem_in[k] = AGE_W'(r2 - {1'b0, tot_ff[k-1]});
            q_in[k]   = {q_ff[k-1][AGE_W-2:0], 1'b1};
         end else begin
            rem_in[k] = r2[AGE_W-1:0];
            q_in[k]   = {q_ff[k-1][AGE_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) v_ff[k] <= 1'b0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < STAGES; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         rem_ff[0]  <= rem_in[0];
         q_ff[0]    <= q_in[0];
         tot_ff[0]  <= in_total;
         full_ff[0] <= full_in0;
         col_ff[0]  <= in_colour;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (rdy[k]) begin
            rem_ff[k]  <= rem_in[k];
            q_ff[k]    <= q_in[k];
            tot_ff[k]  <= tot_ff[k-1];
            full_ff[k] <= full_ff[k-1];
            col_ff[k]  <= col_ff[k-1];
         end
      end
   end

   assign in_ready   = rdy[0];
   assign out_valid  = v_ff[STAGES-1];
   assign out_age    = full_ff[STAGES-1] ? '1 : q_ff[STAGES-1];
   assign out_colour = col_ff[STAGES-1];

endmodule

// File: hw/rtl/lcg_key_interp.sv
// Key search, bracket selection and blend products for the colour gradient.
module lcg_key_interp import lcg_pkg::*; #(
   parameter int MAX_KEYS = MAX_KEYS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                colour_mode,
   input  logic [CSR_IDX_W-1:0]                key_count,
   input  logic [MAX_KEYS-1:0][KEY_WORD_W-1:0] key_words,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [AGE_W-1:0]                    in_age,
   input  rgba_type                            in_colour,
   output logic                                out_valid,
   input  logic                                out_ready,
   output dividend_type                        out_dividend,
   output logic [AGE_W-1:0]                    out_den
);

   localparam int KEY_IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int STAGES    = 4;

   logic v_ff [STAGES];
   logic rdy  [STAGES];

   // stage 0: bracket search
   logic [AGE_W-1:0]     age_ff;
   rgba_type             col0_ff;
   logic [KEY_IDX_W-1:0] lo_ff, hi_ff, lo_in, hi_in;
   logic                 hold_ff, hold_in;
   // stage 1: bracket operands
   logic [NUM_CHAN-1:0][CHAN_W-1:0] ci_ff, cj_ff;
   logic [AGE_W-1:0]     num_ff, den1_ff;
   rgba_type             col1_ff;
   // stage 2: products
   logic [NUM_CHAN-1:0][PROD_W-1:0] p1_ff, p2_ff;
   logic [AGE_W-1:0]     den2_ff;
   logic [NUM_CHAN-1:0][COL_W-1:0] scale2_ff;
   // stage 3: blended numerator
   logic [NUM_CHAN-1:0][NUMER_W-1:0] numer_ff;
   logic [NUM_CHAN-1:0][COL_W-1:0]   scale3_ff;
   logic [AGE_W-1:0]     den3_ff;
   // output: scaled and shifted dividend
   dividend_type         div_ff;
   logic [AGE_W-1:0]     den4_ff;
   logic                 out_v_ff;
   logic                 out_rdy;

   assign out_rdy = !out_v_ff || out_ready;
   always_comb begin
      rdy[STAGES-1] = !v_ff[STAGES-1] || out_rdy;
      for (int k = STAGES - 2; k >= 0; k--) rdy[k] = !v_ff[k] || rdy[k+1];
   end

   always_comb begin
      logic [CSR_IDX_W-1:0] n;
      logic [CSR_IDX_W-1:0] j;
      logic                 found;
      if (key_count == '0) n = CSR_IDX_W'(1);
      else if (key_count > CSR_IDX_W'(MAX_KEYS)) n = CSR_IDX_W'(MAX_KEYS);
      else n = key_count;
      j     = n;
      found = 1'b0;
      for (int k = 0; k < MAX_KEYS; k++) begin
         if (!found && CSR_IDX_W'(k) < n && in_age < key_time(key_words[k])) begin
            found = 1'b1;
            j     = CSR_IDX_W'(k);
         end
      end
      if (j == '0) begin
         lo_in   = '0;
         hi_in   = '0;
         hold_in = 1'b1;
      end else if (j == n) begin
         lo_in   = KEY_IDX_W'(n - CSR_IDX_W'(1));
         hi_in   = KEY_IDX_W'(n - CSR_IDX_W'(1));
         hold_in = 1'b1;
      end else begin
         lo_in   = KEY_IDX_W'(j - CSR_IDX_W'(1));
         hi_in   = KEY_IDX_W'(j);
         hold_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) v_ff[k] <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < STAGES; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
         if (out_rdy) out_v_ff <= v_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         age_ff  <= in_age;
         col0_ff <= in_colour;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         hold_ff <= hold_in;
      end
      if (rdy[1]) begin
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            ci_ff[ch] <= key_chan(key_words[lo_ff], ch);
            cj_ff[ch] <= key_chan(key_words[hi_ff], ch);
         end
         num_ff  <= hold_ff ? '0 : age_ff - key_time(key_words[lo_ff]);
         den1_ff <= hold_ff ? AGE_W'(1)
                            : key_time(key_words[hi_ff]) - key_time(key_words[lo_ff]);
         col1_ff <= col0_ff;
      end
      if (rdy[2]) begin
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            p1_ff[ch]     <= PROD_W'(ci_ff[ch]) * PROD_W'(den1_ff - num_ff);
            p2_ff[ch]     <= PROD_W'(cj_ff[ch]) * PROD_W'(num_ff);
            scale2_ff[ch] <= colour_mode ? col1_ff[ch] : '1;
         end
         den2_ff <= den1_ff;
      end
      if (rdy[3]) begin
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            numer_ff[ch] <= NUMER_W'(p1_ff[ch]) + NUMER_W'(p2_ff[ch]);
         end
         scale3_ff <= scale2_ff;
         den3_ff   <= den2_ff;
      end
      if (out_rdy) begin
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            div_ff[ch] <= DIVIDEND_W'((SCALED_W'(numer_ff[ch]) * SCALED_W'(scale3_ff[ch]))
                                      >> FRAC_SHIFT);
         end
         den4_ff <= den3_ff;
      end
   end

   assign in_ready     = rdy[0];
   assign out_valid    = out_v_ff;
   assign out_dividend = div_ff;
   assign out_den      = den4_ff;

endmodule

// File: hw/rtl/lcg_chan_div.sv
// Per-channel pipelined divider by the key span, with saturation to eight bits.
module lcg_chan_div import lcg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  dividend_type     in_dividend,
   input  logic [AGE_W-1:0] in_den,
   output logic             out_valid,
   input  logic             out_ready,
   output rgba_type         out_colour
);

   localparam int STAGES = QUOT_W + 1;

   typedef logic [NUM_CHAN-1:0][AGE_W-1:0]  rem_type;
   typedef logic [NUM_CHAN-1:0][QUOT_W-1:0] quot_type;

   logic             v_ff   [STAGES];
   logic             rdy    [STAGES];
   rem_type          rem_ff [STAGES];
   rem_type          rem_in [STAGES];
   quot_type         low_ff [STAGES];
   quot_type         q_ff   [STAGES];
   quot_type         q_in   [STAGES];
   logic [AGE_W-1:0] den_ff [STAGES];
   logic             out_v_ff;
   rgba_type         out_col_ff;
   logic             out_rdy;

   assign out_rdy = !out_v_ff || out_ready;
   always_comb begin
      rdy[STAGES-1] = !v_ff[STAGES-1] || out_rdy;
      for (int k = STAGES - 2; k >= 0; k--) rdy[k] = !v_ff[k] || rdy[k+1];
   end

   // the quotient stays below 512, so the top part already sits below the divisor
   always_comb begin
      logic [AGE_W:0] r2;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         rem_in[0][ch] = in_dividend[ch][DIVIDEND_W-1:QUOT_W];
         q_in[0][ch]   = '0;
      end
      for (int k = 1; k < STAGES; k++) begin
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            r2 = {rem_ff[k-1][ch], low_ff[k-1][ch][QUOT_W-1]};
            if (r2 >= {1'b0, den_ff[k-1]}) begin
               rem_in[k][ch] = AGE_W'(r2 - {1'b0, den_ff[k-1]});
               q_in[k][ch]   = {q_ff[k-1][ch][QUOT_W-2:0], 1'b1};
            end else begin
               rem_in[k][ch] = r2[AGE_W-1:0];
               q_in[k][ch]   = {q_ff[k-1][ch][QUOT_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) v_ff[k] <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < STAGES; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
         if (out_rdy) out_v_ff <= v_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         den_ff[0] <= in_den;
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            low_ff[0][ch] <= in_dividend[ch][QUOT_W-1:0];
         end
      end
      for (int k = 1; k < STAGES; k++) begin
         if (rdy[k]) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            den_ff[k] <= den_ff[k-1];
            for (int ch = 0; ch < NUM_CHAN; ch++) begin
               low_ff[k][ch] <= {low_ff[k-1][ch][QUOT_W-2:0], 1'b0};
            end
         end
      end
      if (out_rdy) begin
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            out_col_ff[ch] <= q_ff[STAGES-1][ch][QUOT_W-1] ? '1
                                                           : q_ff[STAGES-1][ch][COL_W-1:0];
         end
      end
   end

   assign in_ready   = rdy[0];
   assign out_valid  = out_v_ff;
   assign out_colour = out_col_ff;

endmodule

// File: hw/rtl/lifetime_colour_gradient.sv
// Top level of the lifetime colour gradient: register file and pipeline hookup.
//
// Colours one particle per request. A request carries the remaining and total
// lifetime and the starting RGBA; the response carries the new RGBA.
// Both channels use valid/ready; csr_ writes set the mode, the key count and
// up to MAX_KEYS gradient keys (index 0 mode, 1 count, 2 onward keys).
// Write the registers only while no request is in flight; csr_ready is
// always high.
// The path holds 33 register stages between request and response: 17 stages
// for the age divider (a load stage and one quotient bit per stage), 5 for key
// search, blend and scale, 11 for the per-channel divide by the key span (a
// load stage, one bit per stage) and saturation.
// Throughput is one request per cycle while rsp_ready holds. Each stage holds its own valid bit,
// so a stalled response only backs up stages that are full, and empty
// stages keep taking requests.
// Synchronous reset empties the pipeline, sets key_count to one and clears
// the mode and all keys.
module lifetime_colour_gradient import lcg_pkg::*; #(
   parameter int MAX_KEYS = MAX_KEYS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [KEY_WORD_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [AGE_W-1:0]      req_life_left,
   input  logic [AGE_W-1:0]      req_life_total,
   input  logic [COL_W-1:0]      req_start_red,
   input  logic [COL_W-1:0]      req_start_green,
   input  logic [COL_W-1:0]      req_start_blue,
   input  logic [COL_W-1:0]      req_start_alpha,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COL_W-1:0]      rsp_out_red,
   output logic [COL_W-1:0]      rsp_out_green,
   output logic [COL_W-1:0]      rsp_out_blue,
   output logic [COL_W-1:0]      rsp_out_alpha
);

   logic                                mode_ff;
   logic [CSR_IDX_W-1:0]                count_ff;
   logic [MAX_KEYS-1:0][KEY_WORD_W-1:0] keys_ff;

   rgba_type         req_colour;
   rgba_type         rsp_colour;
   logic             age_valid, age_ready;
   logic [AGE_W-1:0] age;
   rgba_type         age_colour;
   logic             blend_valid, blend_ready;
   dividend_type     blend_dividend;
   logic [AGE_W-1:0] blend_den;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         count_ff <= CSR_IDX_W'(1);
         keys_ff  <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_COLOUR_MODE) begin
            mode_ff <= csr_data[0];
         end else if (csr_index == CSR_KEY_COUNT) begin
            count_ff <= csr_data[CSR_IDX_W-1:0];
         end else begin
            for (int k = 0; k < MAX_KEYS; k++) begin
               if ({1'b0, csr_index} == (CSR_IDX_W+1)'(CSR_KEY_WORD_0) + (CSR_IDX_W+1)'(k)) begin
                  keys_ff[k] <= csr_data;
               end
            end
         end
      end
   end

   assign req_colour[0] = req_start_red;
   assign req_colour[1] = req_start_green;
   assign req_colour[2] = req_start_blue;
   assign req_colour[3] = req_start_alpha;

   lcg_age_div u_age_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_left    (req_life_left),
      .in_total   (req_life_total),
      .in_colour  (req_colour),
      .out_valid  (age_valid),
      .out_ready  (age_ready),
      .out_age    (age),
      .out_colour (age_colour)
   );

   lcg_key_interp #(.MAX_KEYS(MAX_KEYS)) u_key_interp (
      .clock        (clock),
      .reset        (reset),
      .colour_mode  (mode_ff),
      .key_count    (count_ff),
      .key_words    (keys_ff),
      .in_valid     (age_valid),
      .in_ready     (age_ready),
      .in_age       (age),
      .in_colour    (age_colour),
      .out_valid    (blend_valid),
      .out_ready    (blend_ready),
      .out_dividend (blend_dividend),
      .out_den      (blend_den)
   );

   lcg_chan_div u_chan_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (blend_valid),
      .in_ready    (blend_ready),
      .in_dividend (blend_dividend),
      .in_den      (blend_den),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_colour  (rsp_colour)
   );

   assign rsp_out_red   = rsp_colour[0];
   assign rsp_out_green = rsp_colour[1];
   assign rsp_out_blue  = rsp_colour[2];
   assign rsp_out_alpha = rsp_colour[3];

endmodule

// File: tb/sv/lifetime_colour_gradient_tb.sv
// Self-checking testbench for the lifetime colour gradient block.
`timescale 1ns / 100ps

module lifetime_colour_gradient_tb;
   import lcg_pkg::*;

   class colour_scoreboard;
      bit             mode;
      logic [2:0]     count;
      logic [63:0]    keys [6];
      rgba_type       expected_colours [$];
      int             errors;
      int             checked;

      function void reset_regs();
         mode = 0;
         count = 1;
         foreach (keys[i]) keys[i] = '0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] data);
         if (idx == CSR_COLOUR_MODE) mode = data[0];
         else if (idx == CSR_KEY_COUNT) count = data[2:0];
         else keys[idx - CSR_KEY_WORD_0] = data;
      endfunction

      function void note_request(logic [15:0] left, logic [15:0] total, rgba_type start);
         logic [31:0] age;
         int          n, j;
         logic [63:0] wi, wj;
         logic [63:0] num, den, numer, scale, v;
         rgba_type    res;
         if (left > total) age = 0;
         else if (total == 0) age = 65535;
         else begin
            age = ({16'd0, total - left} << 16) / total;
            if (age > 65535) age = 65535;
         end
         n = count;
         if (n < 1) n = 1;
         if (n > 6) n = 6;
         for (j = 0; j < n; j++)
            if (age < keys[j][63:48]) break;
         if (j == 0) begin
            wi = keys[0]; wj = keys[0]; num = 0; den = 1;
         end else if (j >= n) begin
            wi = keys[n-1]; wj = keys[n-1]; num = 0; den = 1;
         end else begin
            wi = keys[j-1]; wj = keys[j];
            num = age - wi[63:48];
            den = wj[63:48] - wi[63:48];
         end
         for (int ch = 0; ch < 4; ch++) begin
            numer = ((wi >> (36 - 12*ch)) & 64'hFFF) * (den - num)
                  + ((wj >> (36 - 12*ch)) & 64'hFFF) * num;
            scale = mode ? 64'(start[ch]) : 64'd255;
            v = (numer * scale) / (den * 2048);
            res[ch] = (v > 255) ? 8'd255 : v[7:0];
         end
         expected_colours = {expected_colours, res};
      endfunction

      function void check_response(rgba_type got);
         rgba_type e;
         string    names [4] = '{"out_red", "out_green", "out_blue", "out_alpha"};
         checked++;
         if (expected_colours.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         e = expected_colours.pop_front();
         for (int ch = 3; ch >= 0; ch--)
            if (e[ch] !== got[ch]) begin
               $error("%s expected %0d actual %0d", names[ch], e[ch], got[ch]);
               errors++;
            end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = 0;
   logic [63:0] csr_data = 0;
   logic req_valid = 0, req_ready;
   logic [15:0] req_life_left = 0, req_life_total = 1;
   logic [7:0] req_start_red = 0, req_start_green = 0, req_start_blue = 0, req_start_alpha = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [7:0] rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;

   colour_scoreboard sb = new();
   bit no_idle = 0;
   bit hold_off = 0;
   int sent = 0;

   always #4 clock = ~clock;

   lifetime_colour_gradient i_dut (.*);

   // Random receiver with bursts of back-pressure.
   initial begin
      int stall;
      @(negedge clock);
      while (1) begin
         if (hold_off) begin
            rsp_ready <= 0;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         if (!no_idle && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 17);
            rsp_ready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1;
         @(negedge clock);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response({rsp_out_alpha, rsp_out_blue, rsp_out_green, rsp_out_red});

   task automatic write_csr(logic [2:0] idx, logic [63:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic send_request(logic [15:0] left, logic [15:0] total, rgba_type start);
      if (!no_idle && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1;
      req_life_left <= left;
      req_life_total <= total;
      {req_start_alpha, req_start_blue, req_start_green, req_start_red} <= start;
      do @(posedge clock); while (!req_ready);
      sb.note_request(left, total, start);
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.expected_colours.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // Ascending random key set; colour at its extreme now and then.
   task automatic load_gradient(bit mode, int n);
      logic [15:0] t [6];
      logic [63:0] w;
      for (int k = 0; k < 6; k++) t[k] = 16'($urandom_range(0, 65535));
      t.sort();
      write_csr(CSR_COLOUR_MODE, {63'd0, mode});
      write_csr(CSR_KEY_COUNT, 64'(n));
      for (int k = 0; k < 6; k++) begin
         w = {t[k], 48'(($urandom() << 16) ^ $urandom())};
         if ($urandom_range(0, 4) == 0) w[47:0] = {48{1'b1}};
         write_csr(3'(CSR_KEY_WORD_0 + k), w);
      end
   endtask

   function automatic logic [15:0] pick_total();
      case ($urandom_range(0, 3))
         0: return 16'hFFFF;
         1: return 16'($urandom_range(1, 16));
         default: return 16'($urandom_range(1, 65535));
      endcase
   endfunction

   task automatic random_request();
      logic [15:0] total, left;
      total = pick_total();
      case ($urandom_range(0, 9))
         0: left = 16'($urandom_range(0, 65535));
         1: left = total;
         2: left = 16'd0;
         default: left = 16'($urandom_range(0, total));
      endcase
      send_request(left, total, rgba_type'($urandom()));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      sb.reset_regs();

      // Directed: reset values, then fixed keys in both modes.
      send_request(16'd0, 16'd1, '1);
      send_request(16'd65535, 16'd1, '0);
      drain();
      write_csr(CSR_KEY_COUNT, 64'd3);
      write_csr(CSR_KEY_WORD_0, {16'h2000, 12'hFFF, 12'h000, 12'h800, 12'h123});
      write_csr(3'(CSR_KEY_WORD_0 + 1), {16'h8000, 12'h000, 12'hFFF, 12'h400, 12'hFFF});
      write_csr(3'(CSR_KEY_WORD_0 + 2), {16'hFFFF, 12'h800, 12'h800, 12'hFFF, 12'h000});
      for (int m = 0; m < 2; m++) begin
         if (m) begin
            drain();
            write_csr(CSR_COLOUR_MODE, 64'd1);
         end
         send_request(16'd1, 16'd1, '1);
         send_request(16'd65535, 16'd65535, 32'hFF00FF00);
         send_request(16'd0, 16'd65535, '1);
         send_request(16'd0, 16'd1, 32'h00FF00FF);
         send_request(16'd65535, 16'd3, '1);
         send_request(16'd49152, 16'd65535, '1);
         send_request(16'd57344, 16'd65535, '1);
         send_request(16'd16384, 16'd65535, '1);
         send_request(16'd1, 16'd65535, '1);
      end
      drain();
      write_csr(CSR_KEY_COUNT, 64'd0);
      send_request(16'd5, 16'd10, '1);
      drain();
      write_csr(CSR_KEY_COUNT, 64'd7);
      send_request(16'd5, 16'd10, '1);
      drain();

      // Random phases over many gradient settings.
      for (int ph = 0; ph < 12; ph++) begin
         load_gradient(ph[0], (ph < 2) ? (ph == 0 ? 1 : 6) : $urandom_range(1, 6));
         if (ph == 11) no_idle = 1;
         if (ph == 5) hold_off = 1;
         for (int k = 0; k < 118; k++) random_request();
         drain();
      end
      $display("Sent %0d particles over 12 gradient settings, both modes,", sent);
      $display("key counts 0..7 and lifetimes at their extremes; %0d responses checked.",
               sb.checked);
      if (sb.errors == 0 && sb.expected_colours.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
